### hdl/sdc_pkg.sv
// Shared constants, field layout and types of the distortion correction block.
`default_nettype none

package sdc_pkg;

   // Polynomial size and offset scaling
   localparam int MAX_ORDER  = 5;
   localparam int NORM_SHIFT = 13;
   localparam int SIDE       = MAX_ORDER + 1;
   localparam int TAB_DEPTH  = SIDE * SIDE;
   localparam int ADDR_W     = $clog2(TAB_DEPTH);
   localparam int IDX_W      = $clog2(SIDE);

   // Field widths
   localparam int OP_W    = 2;
   localparam int PWR_W   = 3;
   localparam int ORD_W   = 3;
   localparam int COEF_W  = 48;
   localparam int POS_W   = 32;
   localparam int ACC_W   = 64;
   localparam int PROD_W  = 2 * ACC_W;
   localparam int HALF_W  = ACC_W / 2;

   // Request word layout, lowest bit first
   localparam int OFS_PWR_X  = 0;
   localparam int OFS_PWR_Y  = OFS_PWR_X + PWR_W;
   localparam int OFS_COEF   = OFS_PWR_Y + PWR_W;
   localparam int OFS_POS_X  = OFS_COEF + COEF_W;
   localparam int OFS_POS_Y  = OFS_POS_X + POS_W;
   localparam int REQ_BITS   = OFS_POS_Y + POS_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = 2 * POS_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_X   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y   = 2'd3;

   // Opcodes
   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_XFORM  = 2'd2;

   // Fixed point constants
   localparam logic signed [ACC_W-1:0] ONE_Q30 = ACC_W'(64'd1 << 30);
   localparam int SH_SHORT = 30;
   localparam int SH_LONG  = 36;
   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Offset normalization shifts, at most one of them is nonzero
   localparam int NRM_R = (NORM_SHIFT >= 12) ? NORM_SHIFT - 12 : 0;
   localparam int NRM_L = (NORM_SHIFT < 12) ? 12 - NORM_SHIFT : 0;
   localparam int NRM_W = POS_W + 1 + NRM_L;

   // Request to the shared multiplier
   typedef struct packed {
      logic start;
      logic shift_long;
   } mul_req_type;

   // Scale a pixel offset into Q1.30 and clamp to 32 bits
   function automatic logic signed [POS_W-1:0] normalize(input logic signed [POS_W:0] d);
      logic signed [NRM_W-1:0] w;
      logic                    same;
      w    = NRM_W'(d);
      w    = (w <<< NRM_L) >>> NRM_R;
      same = (&w[NRM_W-1:POS_W-1]) || !(|w[NRM_W-1:POS_W-1]);
      if (same) begin
         return w[POS_W-1:0];
      end else if (w[NRM_W-1]) begin
         return POS_MIN;
      end else begin
         return POS_MAX;
      end
   endfunction

endpackage

`default_nettype wire

### hdl/sip_distortion_correction.sv
// Polynomial distortion correction of pixel positions with loadable coefficient tables.
//
// Load words (opcode load A or load B) write one coefficient into its table; they give no
// result. A transform word walks the polynomial on one shared 32x32 multiplier that builds
// each product of two 64-bit operands from four partial products. A transform with effective
// order M (larger of the two clamped orders) costs 2*M power products, M*(M+3)/2 monomials
// and up to two coefficient products per monomial, so none when both orders are zero.
// One item is worked on at a time; the result sits in an output register so the next word
// is taken while it waits, and a transform that finishes while that word still waits holds
// until it is taken. Tables read as zero after reset.
`default_nettype none

module sip_distortion_correction (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // power_x, power_y, coef_value, pos_x, pos_y, zero pad
   input  wire logic [sdc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  wire logic [sdc_pkg::OP_W-1:0]           req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // corr_x, corr_y
   output logic [sdc_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // saturated
   output logic [0:0]                              rsp_tuser,
   input  wire logic                               csr_wr_en,
   input  wire logic [sdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sdc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sdc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_POWX  = 3'd1;
   localparam logic [2:0] ST_POWY  = 3'd2;
   localparam logic [2:0] ST_MONO  = 3'd3;
   localparam logic [2:0] ST_TERMA = 3'd4;
   localparam logic [2:0] ST_TERMB = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // Configuration
   logic [ORD_W-1:0]        order_a_ff, order_b_ff;
   logic signed [POS_W-1:0] ref_x_ff, ref_y_ff;

   // Sequencer state
   logic [2:0]              state_ff, state_in;
   logic                    issued_ff, issued_in;
   logic [IDX_W-1:0]        k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [IDX_W-1:0]        oa_ff, oa_in, ob_ff, ob_in, om_ff, om_in;
   logic signed [POS_W-1:0] u_ff, u_in, v_ff, v_in, px_ff, px_in, py_ff, py_in;
   logic signed [ACC_W-1:0] powx_ff [SIDE];
   logic signed [ACC_W-1:0] powx_in [SIDE];
   logic signed [ACC_W-1:0] powy_ff [SIDE];
   logic signed [ACC_W-1:0] powy_in [SIDE];
   logic signed [ACC_W-1:0] mono_ff, mono_in, sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [TAB_DEPTH-1:0]    vld_a_ff, vld_a_in, vld_b_ff, vld_b_in;

   // Result register
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [POS_W-1:0]        corr_x_ff, corr_x_in, corr_y_ff, corr_y_in;
   logic                    sat_ff, sat_in;

   // Request fields
   logic [PWR_W-1:0]        f_power_x, f_power_y;
   logic [COEF_W-1:0]       f_coef;
   logic signed [POS_W-1:0] f_pos_x, f_pos_y;
   logic                    req_acc, pwr_ok;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic                    wr_a, wr_b;
   logic signed [POS_W:0]   dx, dy;
   logic [IDX_W-1:0]        oa_new, ob_new;

   // Memory and multiplier
   logic [COEF_W-1:0]       rd_a, rd_b;
   logic signed [ACC_W-1:0] coef_a, coef_b;
   mul_req_type             mul_req;
   logic signed [ACC_W-1:0] mul_a, mul_b, mul_res;
   logic                    mul_done;

   // Walk control
   logic [IDX_W-1:0]        k_prev;
   logic [IDX_W:0]          ij_sum;
   logic                    gate_a, gate_b, last_term, busy;
   logic signed [ACC_W-1:0] tot_x, tot_y;
   logic                    clip_x, clip_y;

   // Unpack the request word
   assign f_power_x = req_tdata[OFS_PWR_X +: PWR_W];
   assign f_power_y = req_tdata[OFS_PWR_Y +: PWR_W];
   assign f_coef    = req_tdata[OFS_COEF +: COEF_W];
   assign f_pos_x   = req_tdata[OFS_POS_X +: POS_W];
   assign f_pos_y   = req_tdata[OFS_POS_Y +: POS_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         order_a_ff <= '0;
         order_b_ff <= '0;
         ref_x_ff   <= '0;
         ref_y_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORDER_A: order_a_ff <= csr_wdata[ORD_W-1:0];
            CSR_ORDER_B: order_b_ff <= csr_wdata[ORD_W-1:0];
            CSR_REF_X:   ref_x_ff   <= csr_wdata[POS_W-1:0];
            CSR_REF_Y:   ref_y_ff   <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // Coefficient loads
   assign pwr_ok  = (int'(f_power_x) <= MAX_ORDER) && (int'(f_power_y) <= MAX_ORDER);
   assign wr_addr = ADDR_W'(int'(f_power_x) * SIDE + int'(f_power_y));
   assign wr_a    = req_acc && (req_tuser == OP_LOAD_A) && pwr_ok;
   assign wr_b    = req_acc && (req_tuser == OP_LOAD_B) && pwr_ok;
   assign rd_addr = ADDR_W'(int'(i_ff) * SIDE + int'(j_ff));

   sdc_ram #(.WIDTH(COEF_W), .DEPTH(TAB_DEPTH)) u_tab_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (f_coef),
      .rd_addr (rd_addr),
      .rd_data (rd_a)
   );

   sdc_ram #(.WIDTH(COEF_W), .DEPTH(TAB_DEPTH)) u_tab_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (f_coef),
      .rd_addr (rd_addr),
      .rd_data (rd_b)
   );

   // Entries never loaded read as zero
   assign coef_a = vld_a_ff[rd_addr] ? {{(ACC_W-COEF_W){rd_a[COEF_W-1]}}, rd_a} : '0;
   assign coef_b = vld_b_ff[rd_addr] ? {{(ACC_W-COEF_W){rd_b[COEF_W-1]}}, rd_b} : '0;

   // Offsets and clamped orders at accept
   assign dx     = {f_pos_x[POS_W-1], f_pos_x} - {ref_x_ff[POS_W-1], ref_x_ff};
   assign dy     = {f_pos_y[POS_W-1], f_pos_y} - {ref_y_ff[POS_W-1], ref_y_ff};
   assign oa_new = (int'(order_a_ff) > MAX_ORDER) ? IDX_W'(MAX_ORDER) : IDX_W'(order_a_ff);
   assign ob_new = (int'(order_b_ff) > MAX_ORDER) ? IDX_W'(MAX_ORDER) : IDX_W'(order_b_ff);

   // Multiplier operands per state
   assign k_prev = k_ff - IDX_W'(1);
   assign busy   = (state_ff == ST_POWX) || (state_ff == ST_POWY) || (state_ff == ST_MONO)
                || (state_ff == ST_TERMA) || (state_ff == ST_TERMB);
   assign mul_req.start      = busy && !issued_ff;
   assign mul_req.shift_long = (state_ff == ST_TERMA) || (state_ff == ST_TERMB);

   always_comb begin
      case (state_ff)
         ST_POWX: begin
            mul_a = powx_ff[k_prev];
            mul_b = {{(ACC_W-POS_W){u_ff[POS_W-1]}}, u_ff};
         end
         ST_POWY: begin
            mul_a = powy_ff[k_prev];
            mul_b = {{(ACC_W-POS_W){v_ff[POS_W-1]}}, v_ff};
         end
         ST_MONO: begin
            mul_a = powx_ff[i_ff];
            mul_b = powy_ff[j_ff];
         end
         ST_TERMA: begin
            mul_a = coef_a;
            mul_b = mono_ff;
         end
         ST_TERMB: begin
            mul_a = coef_b;
            mul_b = mono_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   sdc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // Term gating and walk order: i outer, j inner, 1 <= i+j <= M, ending at (M,0)
   assign gate_a    = (i_ff <= oa_ff) && (j_ff <= oa_ff);
   assign gate_b    = (i_ff <= ob_ff) && (j_ff <= ob_ff);
   assign last_term = (i_ff == om_ff);
   assign ij_sum    = {1'b0, i_ff} + {1'b0, j_ff};

   // Final sums and clipping
   assign tot_x  = {{(ACC_W-POS_W){px_ff[POS_W-1]}}, px_ff} + sum_x_ff;
   assign tot_y  = {{(ACC_W-POS_W){py_ff[POS_W-1]}}, py_ff} + sum_y_ff;
   assign clip_x = !((&tot_x[ACC_W-1:POS_W-1]) || !(|tot_x[ACC_W-1:POS_W-1]));
   assign clip_y = !((&tot_y[ACC_W-1:POS_W-1]) || !(|tot_y[ACC_W-1:POS_W-1]));

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      issued_in     = issued_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      oa_in         = oa_ff;
      ob_in         = ob_ff;
      om_in         = om_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      powx_in       = powx_ff;
      powy_in       = powy_ff;
      mono_in       = mono_ff;
      sum_x_in      = sum_x_ff;
      sum_y_in      = sum_y_ff;
      vld_a_in      = vld_a_ff;
      vld_b_in      = vld_b_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      corr_x_in     = corr_x_ff;
      corr_y_in     = corr_y_ff;
      sat_in        = sat_ff;

      // Track one multiply in flight
      if (mul_req.start) begin
         issued_in = 1'b1;
      end else if (mul_done) begin
         issued_in = 1'b0;
      end

      if (wr_a) begin
         vld_a_in[wr_addr] = 1'b1;
      end
      if (wr_b) begin
         vld_b_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == OP_XFORM)) begin
               px_in      = f_pos_x;
               py_in      = f_pos_y;
               u_in       = normalize(dx);
               v_in       = normalize(dy);
               oa_in      = oa_new;
               ob_in      = ob_new;
               om_in      = (oa_new > ob_new) ? oa_new : ob_new;
               powx_in[0] = ONE_Q30;
               powy_in[0] = ONE_Q30;
               sum_x_in   = '0;
               sum_y_in   = '0;
               k_in       = IDX_W'(1);
               if ((oa_new == '0) && (ob_new == '0)) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_POWX;
               end
            end
         end
         ST_POWX: begin
            if (mul_done) begin
               powx_in[k_ff] = mul_res;
               state_in      = ST_POWY;
            end
         end
         ST_POWY: begin
            if (mul_done) begin
               powy_in[k_ff] = mul_res;
               if (k_ff == om_ff) begin
                  i_in     = '0;
                  j_in     = IDX_W'(1);
                  state_in = ST_MONO;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_POWX;
               end
            end
         end
         ST_MONO, ST_TERMA, ST_TERMB: begin
            if (mul_done) begin
               if (state_ff == ST_MONO) begin
                  mono_in = mul_res;
               end else if (state_ff == ST_TERMA) begin
                  sum_x_in = sum_x_ff + mul_res;
               end else begin
                  sum_y_in = sum_y_ff + mul_res;
               end
               // Next product of this term, else advance to the next term
               if ((state_ff == ST_MONO) && gate_a) begin
                  state_in = ST_TERMA;
               end else if ((state_ff != ST_TERMB) && gate_b) begin
                  state_in = ST_TERMB;
               end else if (last_term) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MONO;
                  if (ij_sum < {1'b0, om_ff}) begin
                     j_in = j_ff + IDX_W'(1);
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                     j_in = '0;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               corr_x_in = clip_x ? (tot_x[ACC_W-1] ? POS_MIN : POS_MAX) : tot_x[POS_W-1:0];
               corr_y_in = clip_y ? (tot_y[ACC_W-1] ? POS_MIN : POS_MAX) : tot_y[POS_W-1:0];
               sat_in    = clip_x || clip_y;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issued_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         vld_a_ff      <= '0;
         vld_b_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         issued_ff     <= issued_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         vld_a_ff      <= vld_a_in;
         vld_b_ff      <= vld_b_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      oa_ff     <= oa_in;
      ob_ff     <= ob_in;
      om_ff     <= om_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      powx_ff   <= powx_in;
      powy_ff   <= powy_in;
      mono_ff   <= mono_in;
      sum_x_ff  <= sum_x_in;
      sum_y_ff  <= sum_y_in;
      corr_x_ff <= corr_x_in;
      corr_y_ff <= corr_y_in;
      sat_ff    <= sat_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {corr_y_ff, corr_x_ff};
   assign rsp_tuser  = sat_ff;

endmodule

`default_nettype wire

### hdl/sdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 36
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, register the read data (old contents on a same-address access)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### hdl/sdc_mul.sv
// Shared signed multiplier: trunc(a * b / 2^sh) on a 32x32 unit, four partial products.
`default_nettype none

module sdc_mul (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sdc_pkg::mul_req_type             req,
   input  wire logic signed [sdc_pkg::ACC_W-1:0] op_a,
   input  wire logic signed [sdc_pkg::ACC_W-1:0] op_b,
   output logic                                  done,
   output logic signed [sdc_pkg::ACC_W-1:0]      result
);
   import sdc_pkg::*;

   localparam logic [PROD_W-1:0] CAP = PROD_W'(1) << 62;

   logic [ACC_W-1:0]   mag_a_ff, mag_b_ff;
   logic               neg_ff, long_ff;
   logic               run_ff;
   logic [1:0]         step_ff;
   logic [ACC_W-1:0]   prod_ff;
   logic [1:0]         sel_ff;
   logic               pvld_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic               last_ff;
   logic               done_ff;
   logic signed [ACC_W-1:0] res_ff;

   logic [HALF_W-1:0]  part_a, part_b;
   logic [PROD_W-1:0]  prod_pos;
   logic [PROD_W-1:0]  scaled;
   logic [ACC_W-1:0]   mag_r;

   // Pick the operand halves for this step
   assign part_a = step_ff[1] ? mag_a_ff[ACC_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
   assign part_b = step_ff[0] ? mag_b_ff[ACC_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];

   // Place the partial product at its weight
   always_comb begin
      case (sel_ff)
         2'd0:    prod_pos = {{ACC_W{1'b0}}, prod_ff};
         2'd1,
         2'd2:    prod_pos = {{HALF_W{1'b0}}, prod_ff, {HALF_W{1'b0}}};
         2'd3:    prod_pos = {prod_ff, {ACC_W{1'b0}}};
         default: prod_pos = '0;
      endcase
   end

   // Scale down and cap the magnitude
   always_comb begin
      scaled = long_ff ? (acc_ff >> SH_LONG) : (acc_ff >> SH_SHORT);
      mag_r  = (scaled > CAP) ? CAP[ACC_W-1:0] : scaled[ACC_W-1:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pvld_ff <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         pvld_ff <= run_ff;
         last_ff <= pvld_ff && (sel_ff == 2'd3);
         done_ff <= last_ff;
         if (req.start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Operands, partial products and accumulation
   always_ff @(posedge clock) begin
      if (req.start) begin
         mag_a_ff <= op_a[ACC_W-1] ? -op_a : op_a;
         mag_b_ff <= op_b[ACC_W-1] ? -op_b : op_b;
         neg_ff   <= op_a[ACC_W-1] ^ op_b[ACC_W-1];
         long_ff  <= req.shift_long;
         acc_ff   <= '0;
      end else if (pvld_ff) begin
         acc_ff <= acc_ff + prod_pos;
      end
      prod_ff <= ACC_W'(part_a) * ACC_W'(part_b);
      sel_ff  <= step_ff;
      if (last_ff) begin
         res_ff <= neg_ff ? -$signed(mag_r) : $signed(mag_r);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

### hdl/sdc_checker.sv
// Port-level checks of the distortion correction block and their bind.
`default_nettype none

module sdc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [sdc_pkg::OP_W-1:0]           req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [sdc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic [0:0]                         rsp_tuser
);
   import sdc_pkg::*;

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A transform occupies the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_XFORM) |=> !req_tready)
      else $error("input taken while a transform is running");

   // A coefficient load does not stall the input
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && ((req_tuser == OP_LOAD_A) || (req_tuser == OP_LOAD_B))
      |=> req_tready)
      else $error("coefficient load stalled the input");

   // Saturation flag only with a clipped coordinate
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[POS_W-1:0] == POS_MAX) || (rsp_tdata[POS_W-1:0] == POS_MIN) ||
         (rsp_tdata[RSP_DATA_W-1:POS_W] == POS_MAX) ||
         (rsp_tdata[RSP_DATA_W-1:POS_W] == POS_MIN))
      else $error("saturation flag without a clipped coordinate");

endmodule

bind sip_distortion_correction sdc_checker u_sdc_checker (.*);

`default_nettype wire
